FILE: rtl/core/timed_event_queue_macros.svh
// Assertion macros shared by the timed event queue RTL.
// No dependencies; modules using them must have i_clk and i_rst_n.
`ifndef TIMED_EVENT_QUEUE_MACROS_SVH
`define TIMED_EVENT_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TEQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/teq_pkg.sv
// Types and constants for the timed event queue.
// No dependencies; used by teq_ctrl, teq_datapath and timed_event_queue.
package teq_pkg;

    localparam int TAG_W   = 16;
    localparam int DELAY_W = 32;

    localparam logic ACTION_POST = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_REJECT  = 1'b1;

    typedef struct packed {
        logic               action;
        logic [TAG_W-1:0]   message_tag;
        logic [DELAY_W-1:0] delay_ticks;
    } t_in_item;

    typedef struct packed {
        logic             kind;
        logic [TAG_W-1:0] message_out;
        logic             last;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load_post;   // capture tag and deadline of an incoming post
        logic tick;        // advance the tick counter
        logic insert;      // insert the captured post into the sorted array
        logic pop;         // drop the head entry
        logic load_out;    // load the result register
        logic out_kind;    // kind of the result being loaded
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic head_due;
        logic next_due;
    } t_dp_status;

endpackage

FILE: rtl/core/timed_event_queue.sv
// Top level of the timed event queue: controller plus datapath.
// Depends on teq_pkg, teq_ctrl and teq_datapath.
//
// Deadline-ordered timer queue. A post (action 0) stores message_tag at
// deadline now + delay_ticks, saturated to the top of the TIME_WIDTH range,
// behind any entry with an equal or earlier deadline; if QUEUE_DEPTH entries
// are already held it returns one result with kind 1, the tag and last set.
// A tick (action 1) advances the saturating counter and then returns every
// entry whose deadline is at or before it, earliest first, last set on the
// final one; nothing due gives no result. A post is captured with its
// saturating add, then inserted into the sorted register array; a reject
// is captured, then loaded into the result register. The single result
// register sends one transfer per cycle while the output is ready, and
// output back-pressure stalls both deliveries and rejects.
// A new item is taken once the previous one has finished, even while its
// final result still sits in the result register. No clearing pass at reset.
module timed_event_queue #(
    parameter int QUEUE_DEPTH = 16,   // 2 .. 64 entries
    parameter int TIME_WIDTH  = 32    // 8 .. 64 bit tick counter
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  teq_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output teq_pkg::t_out_item o_out_data
);
    import teq_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencing: one item in flight, one result transfer per cycle while the output is ready
    teq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_action (i_in_data.action),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    // counter, sorted entries, result register
    teq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out_data (o_out_data)
    );

endmodule

FILE: rtl/core/teq_datapath.sv
// Datapath: tick counter, sorted deadline/tag register array and result register.
// Depends on teq_pkg.
module teq_datapath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_WIDTH  = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  teq_pkg::t_in_item   i_in_data,
    input  teq_pkg::t_dp_cmd    i_cmd,
    output teq_pkg::t_dp_status o_status,
    output teq_pkg::t_out_item  o_out_data
);
    import teq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = ((TIME_WIDTH > DELAY_W) ? TIME_WIDTH : DELAY_W) + 1;

    logic [TIME_WIDTH-1:0] r_dl [QUEUE_DEPTH];
    logic [TAG_W-1:0]      r_tg [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0] n_dl [QUEUE_DEPTH];
    logic [TAG_W-1:0]      n_tg [QUEUE_DEPTH];
    logic                  w_le [QUEUE_DEPTH];

    logic [CNT_W-1:0]      r_count;
    logic [TIME_WIDTH-1:0] r_now;
    logic [TIME_WIDTH-1:0] r_new_dl;
    logic [TAG_W-1:0]      r_new_tag;
    t_out_item             r_out;

    logic [SUM_W-1:0]      w_sum;
    logic [TIME_WIDTH-1:0] w_deadline;

    // saturating now + delay
    assign w_sum      = SUM_W'(r_now) + SUM_W'(i_in_data.delay_ticks);
    assign w_deadline = (|w_sum[SUM_W-1:TIME_WIDTH]) ? '1 : w_sum[TIME_WIDTH-1:0];

    assign o_status.full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.head_due = (r_count != '0) && (r_dl[0] <= r_now);
    assign o_status.next_due = (r_count > CNT_W'(1)) && (r_dl[1] <= r_now);
    assign o_out_data        = r_out;

    // next array contents for insert or pop
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_le[i] = (CNT_W'(i) < r_count) && (r_dl[i] <= r_new_dl);
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_dl[i] = r_dl[i];
            n_tg[i] = r_tg[i];
            if (i_cmd.insert) begin
                if (!w_le[i]) begin
                    if (i == 0 || w_le[(i == 0) ? 0 : i - 1]) begin
                        n_dl[i] = r_new_dl;
                        n_tg[i] = r_new_tag;
                    end else begin
                        n_dl[i] = r_dl[(i == 0) ? 0 : i - 1];
                        n_tg[i] = r_tg[(i == 0) ? 0 : i - 1];
                    end
                end
            end else if (i_cmd.pop && i < QUEUE_DEPTH - 1) begin
                n_dl[i] = r_dl[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                n_tg[i] = r_tg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_dl[i] <= n_dl[i];
            r_tg[i] <= n_tg[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_now   <= '0;
        end else begin
            if (i_cmd.insert) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.pop) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.tick && (r_now != '1)) begin
                r_now <= r_now + TIME_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_post) begin
            r_new_dl  <= w_deadline;
            r_new_tag <= i_in_data.message_tag;
        end
        if (i_cmd.load_out) begin
            r_out.kind <= i_cmd.out_kind;
            if (i_cmd.out_kind == KIND_REJECT) begin
                r_out.message_out <= r_new_tag;
                r_out.last        <= 1'b1;
            end else begin
                r_out.message_out <= r_tg[0];
                r_out.last        <= !o_status.next_due;
            end
        end
    end

`include "timed_event_queue_macros.svh"

    `TEQ_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH), "entry count over depth")
    `TEQ_ASSERT_NEXT(a_insert_grows, i_cmd.insert, r_count == $past(r_count) + CNT_W'(1), "insert lost")
    `TEQ_ASSERT_IMPL(a_pop_nonempty, i_cmd.pop, r_count != '0, "pop from empty queue")

endmodule

FILE: rtl/core/teq_ctrl.sv
// Controller: sequences post, reject and tick/delivery for one item at a time.
// Depends on teq_pkg; drives the datapath through t_dp_cmd.
module teq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_action,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output teq_pkg::t_dp_cmd    o_cmd,
    input  teq_pkg::t_dp_status i_status
);
    import teq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_REJECT,
        S_DRAIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;
    logic   w_slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_action == ACTION_POST) begin
                        o_cmd.load_post = 1'b1;
                        n_state = i_status.full ? S_REJECT : S_INSERT;
                    end else begin
                        o_cmd.tick = 1'b1;
                        n_state    = S_DRAIN;
                    end
                end
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = S_IDLE;
            end
            S_REJECT: begin
                if (w_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_kind = KIND_REJECT;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DRAIN: begin
                if (!i_status.head_due) begin
                    n_state = S_IDLE;
                end else if (w_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_kind = KIND_DELIVER;
                    o_cmd.pop      = 1'b1;
                    n_out_valid    = 1'b1;
                    if (!i_status.next_due) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`include "timed_event_queue_macros.svh"

    `TEQ_ASSERT_IMPL(a_no_overwrite, o_cmd.load_out, !r_out_valid || i_out_ready, "pending result overwritten")
    `TEQ_ASSERT_IMPL(a_pop_only_due, o_cmd.pop, i_status.head_due, "popped an entry not yet due")
    `TEQ_ASSERT_IMPL(a_insert_room, o_cmd.insert, !i_status.full, "insert into full queue")

endmodule
